/* src/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and codes for the signal aspect controller: configuration
// register indexes, classified operation codes and signal status codes.
// ----------------------------------------------------------------------------
package sac_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_SIG_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_ADDR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LVL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SW_DELAY   = 3'd5;

	// Geometry
	localparam int NSIG   = 4;
	localparam int ADDR_W = 16;
	localparam int LVL_W  = 8;
	localparam int QDEPTH = 2;

	// Reset values
	localparam logic [LVL_W-1:0]  DAY_LEVEL_RST   = 8'd255;
	localparam logic [LVL_W-1:0]  NIGHT_LEVEL_RST = 8'd64;
	localparam logic [LVL_W-1:0]  SW_DELAY_RST    = 8'd2;
	localparam logic [LVL_W-1:0]  COUNT_MAX       = 8'd255;
	localparam logic [ADDR_W-1:0] LAST_ADDR_RST   = 16'hFFFF;

	// Operation codes handed from front to back
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_TICK   = 3'd1;
	localparam logic [2:0] OP_DAY    = 3'd2;
	localparam logic [2:0] OP_NIGHT  = 3'd3;
	localparam logic [2:0] OP_SWITCH = 3'd4;

	// Signal status codes
	localparam logic [1:0] ST_A0_ACT  = 2'd0;
	localparam logic [1:0] ST_A0_PEND = 2'd1;
	localparam logic [1:0] ST_A1_ACT  = 2'd2;
	localparam logic [1:0] ST_A1_PEND = 2'd3;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] sig;
		logic       aspect;
	} sac_op_t;

endpackage

/* src/sac_front.sv */
// ----------------------------------------------------------------------------
// sac_front
// Accepts input items, marks repeated commands as no-ops and matches the
// address against configured day, night and signal addresses by priority.
// ----------------------------------------------------------------------------
module sac_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               cmd,
	input  logic [sac_pkg::ADDR_W-1:0]         address,
	input  logic                               q_full,
	output logic                               push,
	output sac_pkg::sac_op_t                   push_op,
	input  logic                               cfg_wr_en,
	input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [63:0]                 sig_low_q;
	logic [63:0]                 sig_high_q;
	logic [31:0]                 night_addrs_q;
	logic [sac_pkg::ADDR_W-1:0]  last_addr_q;
	logic [127:0]                sig_words;
	logic                        is_new;

	assign push      = in_valid && !q_full;
	assign sig_words = {sig_high_q, sig_low_q};
	assign is_new    = (address != last_addr_q);

	// Hold address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_low_q     <= '0;
			sig_high_q    <= '0;
			night_addrs_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sac_pkg::CFG_SIG_LOW:    sig_low_q     <= cfg_data;
				sac_pkg::CFG_SIG_HIGH:   sig_high_q    <= cfg_data;
				sac_pkg::CFG_NIGHT_ADDR: night_addrs_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Track the last new command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_addr_q <= sac_pkg::LAST_ADDR_RST;
		end else if (push && !cmd && is_new) begin
			last_addr_q <= address;
		end
	end

	// Classify the item; the first match in priority order wins
	always_comb begin
		push_op = '{op: sac_pkg::OP_NONE, sig: 2'd0, aspect: 1'b0};
		if (cmd) begin
			push_op.op = sac_pkg::OP_TICK;
		end else if (is_new) begin
			if (address == night_addrs_q[15:0]) begin
				push_op.op = sac_pkg::OP_DAY;
			end else if (address == night_addrs_q[31:16]) begin
				push_op.op = sac_pkg::OP_NIGHT;
			end else begin
				for (int k = 7; k >= 0; k--) begin
					if (address == sig_words[k*16 +: 16]) begin
						push_op.op     = sac_pkg::OP_SWITCH;
						push_op.sig    = 2'(k >> 1);
						push_op.aspect = 1'(k & 1);
					end
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_tick_class: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd) |-> (push_op.op == sac_pkg::OP_TICK))
		else $error("tick item not classified as tick");
`endif

endmodule

/* src/sac_queue.sv */
// ----------------------------------------------------------------------------
// sac_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module sac_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sac_pkg::sac_op_t push_op,
	input  logic             pop,
	output sac_pkg::sac_op_t pop_op,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(sac_pkg::QDEPTH);
	localparam int CNT_W = $clog2(sac_pkg::QDEPTH + 1);

	sac_pkg::sac_op_t   entries_q [sac_pkg::QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(sac_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = entries_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sac_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sac_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(sac_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointer gap");
`endif

endmodule

/* src/sac_back.sv */
// ----------------------------------------------------------------------------
// sac_back
// Carries out classified operations on the four signals and registers the
// lamp levels and monitor pulse for each item.
// ----------------------------------------------------------------------------
module sac_back (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_empty,
	input  sac_pkg::sac_op_t                            pop_op,
	output logic                                        pop,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic [sac_pkg::NSIG-1:0][sac_pkg::LVL_W-1:0] red_q,
	output logic [sac_pkg::NSIG-1:0][sac_pkg::LVL_W-1:0] green_q,
	output logic                                        pulse_q,
	input  logic                                        cfg_wr_en,
	input  logic [sac_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]              cfg_data
);

	localparam int NSIG  = sac_pkg::NSIG;
	localparam int LVL_W = sac_pkg::LVL_W;

	logic [LVL_W-1:0]          day_level_q;
	logic [LVL_W-1:0]          night_level_q;
	logic [LVL_W-1:0]          sw_delay_q;
	logic                      night_q;
	logic [NSIG-1:0][1:0]      status_q;
	logic [NSIG-1:0][LVL_W-1:0] lit_q;
	logic [NSIG-1:0][LVL_W-1:0] count_q;
	logic                      out_valid_q;

	logic                      night_n;
	logic [NSIG-1:0][1:0]      status_n;
	logic [NSIG-1:0][LVL_W-1:0] lit_n;
	logic [NSIG-1:0][LVL_W-1:0] count_n;
	logic                      pulse_n;
	logic [LVL_W-1:0]          level;
	logic [LVL_W-1:0]          tick_level;
	logic [1:0]                act_code;
	logic [1:0]                pend_code;

	assign pop        = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign act_code   = {pop_op.aspect, 1'b0};
	assign pend_code  = {pop_op.aspect, 1'b1};
	assign tick_level = night_q ? night_level_q : day_level_q;
	assign level      = night_n ? night_level_q : day_level_q;

	// Hold level and delay registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_level_q   <= sac_pkg::DAY_LEVEL_RST;
			night_level_q <= sac_pkg::NIGHT_LEVEL_RST;
			sw_delay_q    <= sac_pkg::SW_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sac_pkg::CFG_DAY_LEVEL: day_level_q   <= cfg_data[LVL_W-1:0];
				sac_pkg::CFG_NIGHT_LVL: night_level_q <= cfg_data[LVL_W-1:0];
				sac_pkg::CFG_SW_DELAY:  sw_delay_q    <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Apply the operation, then light any pending signal whose delay is up
	always_comb begin
		night_n  = night_q;
		status_n = status_q;
		lit_n    = lit_q;
		count_n  = count_q;
		pulse_n  = 1'b0;
		unique case (pop_op.op)
			sac_pkg::OP_TICK: begin
				for (int i = 0; i < NSIG; i++) begin
					if (count_q[i] != sac_pkg::COUNT_MAX) begin
						count_n[i] = count_q[i] + 1'b1;
					end
					if (status_q[i] == sac_pkg::ST_A0_ACT || status_q[i] == sac_pkg::ST_A1_ACT) begin
						lit_n[i] = tick_level;
					end
				end
			end
			sac_pkg::OP_DAY: begin
				night_n = 1'b0;
				pulse_n = 1'b1;
			end
			sac_pkg::OP_NIGHT: begin
				night_n = 1'b1;
				pulse_n = 1'b1;
			end
			sac_pkg::OP_SWITCH: begin
				pulse_n = 1'b1;
				if (status_q[pop_op.sig] != act_code && status_q[pop_op.sig] != pend_code) begin
					status_n[pop_op.sig] = pend_code;
					count_n[pop_op.sig]  = '0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NSIG; i++) begin
			if ((status_n[i] == sac_pkg::ST_A0_PEND || status_n[i] == sac_pkg::ST_A1_PEND)
					&& count_n[i] >= sw_delay_q) begin
				lit_n[i]    = level;
				status_n[i] = (status_n[i] == sac_pkg::ST_A0_PEND) ?
					sac_pkg::ST_A0_ACT : sac_pkg::ST_A1_ACT;
			end
		end
	end

	// Advance signal state on each popped operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q <= 1'b0;
			for (int i = 0; i < NSIG; i++) begin
				status_q[i] <= sac_pkg::ST_A0_ACT;
				lit_q[i]    <= sac_pkg::DAY_LEVEL_RST;
				count_q[i]  <= '0;
			end
		end else if (pop) begin
			night_q  <= night_n;
			status_q <= status_n;
			lit_q    <= lit_n;
			count_q  <= count_n;
		end
	end

	// Register the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pulse_q <= pulse_n;
			for (int i = 0; i < NSIG; i++) begin
				red_q[i]   <= (status_n[i] == sac_pkg::ST_A0_ACT) ? lit_n[i] : '0;
				green_q[i] <= (status_n[i] == sac_pkg::ST_A1_ACT) ? lit_n[i] : '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped operation produced no result");
	a_pulse_op: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (pop_op.op == sac_pkg::OP_TICK || pop_op.op == sac_pkg::OP_NONE)) |=> !pulse_q)
		else $error("pulse raised for tick or unmatched command");
`endif

endmodule

/* src/signal_aspect_controller.sv */
// ----------------------------------------------------------------------------
// signal_aspect_controller
// Drives four two-aspect signals from decoded command addresses and
// one-second ticks, with day and night lamp levels and a switch delay.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   in       | input     | in_valid, in_stall  | cmd, address
//   out      | output    | out_valid, out_stall| red_1..4, green_1..4, pulse
//   cfg      | input     | cfg_wr_en           | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item
// waits in the queue and its result is held in the output register (front
// classifies into a two-entry queue, back updates the signals and registers
// the result). in_stall rises only while the queue is full, which happens
// when out_stall holds the output register. Reset returns every signal to
// aspect 0 at day level and restores the register defaults.
// ----------------------------------------------------------------------------
module signal_aspect_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [15:0]                        address,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         red_1,
	output logic [7:0]                         green_1,
	output logic [7:0]                         red_2,
	output logic [7:0]                         green_2,
	output logic [7:0]                         red_3,
	output logic [7:0]                         green_3,
	output logic [7:0]                         red_4,
	output logic [7:0]                         green_4,
	output logic                               monitor_pulse,
	input  logic                               cfg_wr_en,
	input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data
);

	sac_pkg::sac_op_t push_op;
	sac_pkg::sac_op_t pop_op;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	logic [sac_pkg::NSIG-1:0][sac_pkg::LVL_W-1:0] red;
	logic [sac_pkg::NSIG-1:0][sac_pkg::LVL_W-1:0] green;

	assign in_stall = q_full;

	sac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.address   (address),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sac_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	sac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop_op    (pop_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_q     (red),
		.green_q   (green),
		.pulse_q   (monitor_pulse),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Spread lamp levels onto the ports
	assign red_1   = red[0];
	assign green_1 = green[0];
	assign red_2   = red[1];
	assign green_2 = green[1];
	assign red_3   = red[2];
	assign green_3 = green[2];
	assign red_4   = red[3];
	assign green_4 = green[3];

endmodule
